@@ rtl/sst_pkg.sv @@
// ----------------------------------------------------------------------------
// sst_pkg: shared types and constants for the spiral scan tile sequencer
// Holds the beat payload types, the configuration register map and reset
// values, and the spiral leg codes.
// ----------------------------------------------------------------------------
`default_nettype none

package sst_pkg;

    localparam int unsigned MaxRowsDefault = 16;
    localparam int unsigned MaxColsDefault = 16;

    localparam int unsigned GridW   = 5;
    localparam int unsigned PeriodW = 16;
    localparam int unsigned CountW  = 18;
    localparam int unsigned OutIdxW = 4;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDataW = 16;

    localparam logic [GridW-1:0]   GridRowsReset   = 5'd16;
    localparam logic [GridW-1:0]   GridColsReset   = 5'd16;
    localparam logic [PeriodW-1:0] StepPeriodReset = 16'd1000;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_GRID_ROWS   = 2'd0,
        CFG_GRID_COLS   = 2'd1,
        CFG_STEP_PERIOD = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        KIND_TICK  = 1'b0,
        KIND_START = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        LEG_TOP    = 2'd0,
        LEG_RIGHT  = 2'd1,
        LEG_BOTTOM = 2'd2,
        LEG_LEFT   = 2'd3
    } t_leg;

    typedef struct packed {
        logic                kind;
        logic [PeriodW-1:0]  elapsed;
    } t_in_item;

    typedef struct packed {
        logic                spawn_valid;
        logic [OutIdxW-1:0]  row;
        logic [OutIdxW-1:0]  col;
        logic                done_res;
    } t_out_item;

    typedef struct packed {
        logic [GridW-1:0]    grid_rows;
        logic [GridW-1:0]    grid_cols;
        logic [PeriodW-1:0]  step_period;
    } t_cfg;

endpackage

`default_nettype wire

@@ rtl/sst_in_if.sv @@
// ----------------------------------------------------------------------------
// sst_in_if: input channel of the spiral scan tile sequencer
// Valid/ready channel carrying one tick or start beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface sst_in_if;
    logic              valid;
    logic              ready;
    sst_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/sst_out_if.sv @@
// ----------------------------------------------------------------------------
// sst_out_if: result channel of the spiral scan tile sequencer
// Valid/ready channel carrying one emitted cell beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface sst_out_if;
    logic               valid;
    logic               ready;
    sst_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/spiral_scan_tile_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// spiral_scan_tile_sequencer_unit: paced clockwise spiral scan of a grid
// Top level: configuration registers, step stage and result register.
// ----------------------------------------------------------------------------
// Accepts one beat per clock cycle unless the result register stalls it; the
// step stage updates the countdown and spiral walk state in one pass. A start
// beat latches the clamped grid size and restarts the scan at the top-left cell
// with the countdown at zero; while armed, each tick beat subtracts its elapsed
// time, and when the countdown drops below zero the next clockwise cell is
// emitted and the countdown reloads with step_period. The last cell carries
// done_res and disarms the scan. A beat passes an input register and a result
// register. Configuration is to be written only while no beat is in flight;
// the block does not enforce this. Grid size applies at the next start,
// step_period at the next reload.
`default_nettype none

module spiral_scan_tile_sequencer_unit #(
    parameter int unsigned MAX_ROWS = sst_pkg::MaxRowsDefault,
    parameter int unsigned MAX_COLS = sst_pkg::MaxColsDefault
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [sst_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  wire logic [sst_pkg::CfgDataW-1:0]  i_cfg_data,
    sst_in_if.sink                             i_in,
    sst_out_if.source                          o_out
);
    import sst_pkg::*;

    t_cfg      r_cfg;
    logic      res_valid;
    logic      res_ready;
    t_out_item res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_rows   <= GridRowsReset;
            r_cfg.grid_cols   <= GridColsReset;
            r_cfg.step_period <= StepPeriodReset;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_GRID_ROWS:   r_cfg.grid_rows   <= i_cfg_data[GridW-1:0];
                CFG_GRID_COLS:   r_cfg.grid_cols   <= i_cfg_data[GridW-1:0];
                CFG_STEP_PERIOD: r_cfg.step_period <= i_cfg_data[PeriodW-1:0];
                default: ;  // drop writes to unmapped indexes
            endcase
        end
    end

    sst_core #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in        (i_in),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    sst_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_res_ready (res_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

@@ rtl/sst_core.sv @@
// ----------------------------------------------------------------------------
// sst_core: input register and spiral step stage
// Registers each accepted beat, then in one pass updates the countdown and
// the spiral walk state and offers an emitted cell to the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_core #(
    parameter int unsigned MAX_ROWS = sst_pkg::MaxRowsDefault,
    parameter int unsigned MAX_COLS = sst_pkg::MaxColsDefault
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire sst_pkg::t_cfg      i_cfg,
    sst_in_if.sink                  i_in,
    output logic                    o_res_valid,
    output sst_pkg::t_out_item      o_res,
    input  wire logic               i_res_ready
);
    import sst_pkg::*;

    localparam int unsigned RowW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int unsigned ColW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int unsigned RDimW = $clog2(MAX_ROWS + 1);
    localparam int unsigned CDimW = $clog2(MAX_COLS + 1);
    localparam int unsigned CellW = $clog2(MAX_ROWS * MAX_COLS + 1);
    localparam int unsigned ExtW  = 9;

    // input register
    logic      r_in_valid;
    t_in_item  r_in;

    // spiral state
    logic                     r_armed, n_armed;
    logic signed [CountW-1:0] r_countdown, n_countdown;
    logic [RowW-1:0]          r_top, n_top, r_bottom, n_bottom;
    logic [ColW-1:0]          r_left, n_left, r_right, n_right;
    t_leg                     r_leg, n_leg;
    logic [RowW-1:0]          r_cur_row, n_cur_row;
    logic [ColW-1:0]          r_cur_col, n_cur_col;
    logic [CellW-1:0]         r_cells_left, n_cells_left;

    logic                     go;
    logic [ExtW-1:0]          rows_ext, cols_ext;
    logic [RDimW-1:0]         rows;
    logic [CDimW-1:0]         cols;
    logic signed [CountW-1:0] diff;

    assign go         = r_in_valid && i_res_ready;
    assign i_in.ready = !r_in_valid || go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
    end

    // clamp grid size: zero counts as one, above the maximum counts as it
    always_comb begin
        rows_ext = {{(ExtW-GridW){1'b0}}, i_cfg.grid_rows};
        cols_ext = {{(ExtW-GridW){1'b0}}, i_cfg.grid_cols};
        if (rows_ext == '0) begin
            rows = RDimW'(1);
        end else if (rows_ext > ExtW'(MAX_ROWS)) begin
            rows = RDimW'(MAX_ROWS);
        end else begin
            rows = RDimW'(rows_ext);
        end
        if (cols_ext == '0) begin
            cols = CDimW'(1);
        end else if (cols_ext > ExtW'(MAX_COLS)) begin
            cols = CDimW'(MAX_COLS);
        end else begin
            cols = CDimW'(cols_ext);
        end
    end

    assign diff = r_countdown - $signed({{(CountW-PeriodW){1'b0}}, r_in.elapsed});

    always_comb begin
        n_armed      = r_armed;
        n_countdown  = r_countdown;
        n_top        = r_top;
        n_bottom     = r_bottom;
        n_left       = r_left;
        n_right      = r_right;
        n_leg        = r_leg;
        n_cur_row    = r_cur_row;
        n_cur_col    = r_cur_col;
        n_cells_left = r_cells_left;
        o_res_valid  = 1'b0;
        o_res.spawn_valid = 1'b1;
        o_res.row         = OutIdxW'(r_cur_row);
        o_res.col         = OutIdxW'(r_cur_col);
        o_res.done_res    = (r_cells_left == CellW'(1));

        if (go) begin
            if (r_in.kind == KIND_START) begin
                n_armed      = 1'b1;
                n_countdown  = '0;
                n_top        = '0;
                n_left       = '0;
                n_bottom     = RowW'(rows - RDimW'(1));
                n_right      = ColW'(cols - CDimW'(1));
                n_leg        = LEG_TOP;
                n_cur_row    = '0;
                n_cur_col    = '0;
                n_cells_left = CellW'(rows) * CellW'(cols);
            end else if (r_armed) begin
                n_countdown = diff;
                if (diff[CountW-1]) begin
                    o_res_valid  = 1'b1;
                    n_countdown  = $signed({{(CountW-PeriodW){1'b0}}, i_cfg.step_period});
                    n_cells_left = r_cells_left - CellW'(1);
                    if (r_cells_left == CellW'(1)) begin
                        n_armed = 1'b0;
                    end else begin
                        // walk one cell clockwise; turn and shrink the ring at a corner
                        case (r_leg)
                            LEG_TOP: begin
                                if (r_cur_col < r_right) begin
                                    n_cur_col = r_cur_col + ColW'(1);
                                end else begin
                                    n_top     = r_top + RowW'(1);
                                    n_leg     = LEG_RIGHT;
                                    n_cur_row = r_cur_row + RowW'(1);
                                end
                            end
                            LEG_RIGHT: begin
                                if (r_cur_row < r_bottom) begin
                                    n_cur_row = r_cur_row + RowW'(1);
                                end else begin
                                    n_right   = r_right - ColW'(1);
                                    n_leg     = LEG_BOTTOM;
                                    n_cur_col = r_cur_col - ColW'(1);
                                end
                            end
                            LEG_BOTTOM: begin
                                if (r_cur_col > r_left) begin
                                    n_cur_col = r_cur_col - ColW'(1);
                                end else begin
                                    n_bottom  = r_bottom - RowW'(1);
                                    n_leg     = LEG_LEFT;
                                    n_cur_row = r_cur_row - RowW'(1);
                                end
                            end
                            default: begin
                                if (r_cur_row > r_top) begin
                                    n_cur_row = r_cur_row - RowW'(1);
                                end else begin
                                    n_left    = r_left + ColW'(1);
                                    n_leg     = LEG_TOP;
                                    n_cur_col = r_cur_col + ColW'(1);
                                end
                            end
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed      <= 1'b0;
            r_countdown  <= '0;
            r_top        <= '0;
            r_bottom     <= '0;
            r_left       <= '0;
            r_right      <= '0;
            r_leg        <= LEG_TOP;
            r_cur_row    <= '0;
            r_cur_col    <= '0;
            r_cells_left <= '0;
        end else begin
            r_armed      <= n_armed;
            r_countdown  <= n_countdown;
            r_top        <= n_top;
            r_bottom     <= n_bottom;
            r_left       <= n_left;
            r_right      <= n_right;
            r_leg        <= n_leg;
            r_cur_row    <= n_cur_row;
            r_cur_col    <= n_cur_col;
            r_cells_left <= n_cells_left;
        end
    end

endmodule

`default_nettype wire

@@ rtl/sst_out_reg.sv @@
// ----------------------------------------------------------------------------
// sst_out_reg: result register of the spiral scan tile sequencer
// Holds one emitted cell beat until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_out_reg (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_res_valid,
    input  wire sst_pkg::t_out_item  i_res,
    output logic                     o_res_ready,
    sst_out_if.source                o_out
);
    import sst_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    // take a new beat when empty or when the held one leaves this cycle
    assign o_res_ready = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_ready && i_res_valid) begin
            r_item <= i_res;
        end
    end

    assign o_out.valid = r_valid;
    assign o_out.data  = r_item;

endmodule

`default_nettype wire
